FILE: rtl/core/asfc_pkg.sv
// Package: format codes and per-format constants for the sample converter
`default_nettype none
package asfc_pkg;
  typedef enum logic [1:0] {
    FMT_S16 = 2'd0,
    FMT_S24 = 2'd1,
    FMT_S32 = 2'd2,
    FMT_F32 = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    REG_SRC = 2'd0,
    REG_DST = 2'd1,
    REG_NONE2 = 2'd2,
    REG_NONE3 = 2'd3
  } reg_e;

  // scale exponent k = width - 1
  function automatic logic [4:0] fmt_k(input logic [1:0] f);
    case (f)
      FMT_S16: fmt_k = 5'd15;
      FMT_S24: fmt_k = 5'd23;
      default: fmt_k = 5'd31;
    endcase
  endfunction

  function automatic logic [31:0] fmt_limit(input logic [1:0] f);
    case (f)
      FMT_S16: fmt_limit = 32'd32767;
      FMT_S24: fmt_limit = 32'd8388607;
      default: fmt_limit = 32'd2147483520;
    endcase
  endfunction

  function automatic logic [31:0] sext(input logic [31:0] x, input logic [1:0] f);
    case (f)
      FMT_S16: sext = {{16{x[15]}}, x[15:0]};
      FMT_S24: sext = {{8{x[23]}}, x[23:0]};
      default: sext = x;
    endcase
  endfunction
endpackage
`default_nettype wire

FILE: rtl/core/audio_sample_format_converter.sv
// Top level: pipelined PCM / float sample format converter with APB registers
//
// channel | handshake          | payload
// in      | in_valid/in_ready  | sample_in_i[31:0], last_in_i
// out     | out_valid/out_ready| sample_out_o[31:0], last_out_o
// cfg     | APB psel/penable   | paddr[2:0], pwdata/prdata[31:0]
//
// Four register stages: decode, normalize/shift, round/clamp, output.
// One item per cycle sustained while the output is not stalled.
// Reset clears valid bits and sets source s16, dest f32.
// A stall at the output freezes every stage; bubbles stay in place.
`default_nettype none
module audio_sample_format_converter
  import asfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] sample_in_i,
  input  wire logic        last_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      sample_out_o,
  output logic             last_out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [1:0] src_q, dst_q;
  reg_e       ridx;
  assign ridx   = reg_e'({1'b0, paddr[2]});
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= FMT_S16;
      dst_q <= FMT_F32;
    end else if (psel && penable && pwrite) begin
      if (ridx == REG_SRC) src_q <= pwdata[1:0];
      if (ridx == REG_DST) dst_q <= pwdata[1:0];
    end
  end

  always_comb begin
    case (ridx)
      REG_SRC: prdata = {30'd0, src_q};
      REG_DST: prdata = {30'd0, dst_q};
      default: prdata = 32'd0;
    endcase
  end

  // stage valids; whole pipe advances when output can move
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv;
  assign adv        = !v4_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 1: decode ----------------
  typedef enum logic [2:0] {
    OP_PASS  = 3'd0,
    OP_ISHL  = 3'd1,
    OP_ISHR  = 3'd2,
    OP_I2F   = 3'd3,
    OP_F2I   = 3'd4
  } op_e;

  op_e         op1_q;
  logic [31:0] v1d_q;   // sign-extended int or raw float
  logic [4:0]  amt1_q;  // shift amount or k
  logic [31:0] lim1_q;
  logic        l1_q;

  op_e         op1_d;
  logic [31:0] v1d_d;
  logic [4:0]  amt1_d;
  logic [4:0]  ks, kd;

  always_comb begin
    ks     = fmt_k(src_q);
    kd     = fmt_k(dst_q);
    v1d_d  = sample_in_i;
    amt1_d = 5'd0;
    op1_d  = OP_PASS;
    if (src_q == FMT_F32) begin
      if (dst_q != FMT_F32) begin
        op1_d  = OP_F2I;
        amt1_d = kd;
      end
    end else begin
      v1d_d = sext(sample_in_i, src_q);
      if (dst_q == FMT_F32) begin
        op1_d  = OP_I2F;
        amt1_d = ks;
      end else if (kd >= ks) begin
        op1_d  = OP_ISHL;
        amt1_d = kd - ks;
      end else begin
        op1_d  = OP_ISHR;
        amt1_d = ks - kd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op1_q  <= op1_d;
      v1d_q  <= v1d_d;
      amt1_q <= amt1_d;
      lim1_q <= fmt_limit(dst_q);
      l1_q   <= last_in_i;
    end
  end

  // ---------------- stage 2: normalize / align ----------------
  // I2F: magnitude, leading-one position p, mantissa left-aligned (32 bits)
  // F2I: aligned magnitude (saturate flag), sign
  logic [31:0] mag2, norm2;
  logic [4:0]  p2;
  logic        sgn2, sat2, nan2, zero2;
  logic [39:0] fwide2;
  logic [8:0]  sh2;
  logic [23:0] sig2;
  logic [7:0]  fe2;
  logic [31:0] r2;

  always_comb begin
    sgn2  = v1d_q[31];
    mag2  = sgn2 ? (~v1d_q + 32'd1) : v1d_q;
    p2    = 5'd0;
    for (int i = 0; i < 32; i++) if (mag2[i]) p2 = 5'(i);
    norm2 = mag2 << (5'd31 - p2);
    zero2 = (v1d_q == 32'd0);
    // float decode
    fe2   = v1d_q[30:23];
    sig2  = (fe2 == 8'd0) ? {1'b0, v1d_q[22:0]} : {1'b1, v1d_q[22:0]};
    nan2  = (fe2 == 8'hFF) && (v1d_q[22:0] != 23'd0);
    // shift = max(e,1) - 150 + k, biased by +150
    sh2   = 9'((fe2 == 8'd0) ? 8'd1 : fe2) + 9'(amt1_q);
    sat2  = (fe2 == 8'hFF) || (sh2 >= 9'd158);
    fwide2 = 40'd0;
    if (sh2 >= 9'd150) fwide2 = {16'd0, sig2} << 4'(sh2 - 9'd150);
    else if (sh2 > 9'd118) fwide2 = {16'd0, sig2 >> 5'(9'd150 - sh2)};
    case (op1_q)
      OP_ISHL: r2 = v1d_q << amt1_q;
      OP_ISHR: r2 = 32'($signed(v1d_q) >>> amt1_q);
      default: r2 = v1d_q;
    endcase
  end

  op_e         op2_q;
  logic [31:0] r2_q, norm2_q, lim2_q;
  logic [39:0] fw2_q;
  logic [4:0]  p2_q, k2_q;
  logic        sgn2_q, sat2_q, nan2_q, zero2_q, l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      op2_q   <= op1_q;
      r2_q    <= r2;
      norm2_q <= norm2;
      fw2_q   <= fwide2;
      p2_q    <= p2;
      k2_q    <= amt1_q;
      sgn2_q  <= sgn2;
      sat2_q  <= sat2;
      nan2_q  <= nan2;
      zero2_q <= zero2;
      lim2_q  <= lim1_q;
      l2_q    <= l1_q;
    end
  end

  // ---------------- stage 3: round / clamp ----------------
  logic [24:0] q3;
  logic        rnd3;
  logic [8:0]  p3;
  logic [31:0] mag3, r3;

  always_comb begin
    rnd3 = norm2_q[7] && (norm2_q[6:0] != 7'd0 || norm2_q[8]);
    q3   = {1'b0, norm2_q[31:8]} + 25'(rnd3);
    p3   = 9'(p2_q);
    if (q3[24]) begin
      q3 = q3 >> 1;
      p3 = p3 + 9'd1;
    end
    mag3 = (sat2_q || fw2_q > 40'(lim2_q)) ? lim2_q : fw2_q[31:0];
    case (op2_q)
      OP_I2F: begin
        if (zero2_q) r3 = 32'd0;
        else r3 = {sgn2_q, 8'(p3 + 9'd127 - 9'(k2_q)), q3[22:0]};
      end
      OP_F2I: begin
        if (nan2_q) r3 = 32'd0;
        else r3 = sgn2_q ? (32'd0 - mag3) : mag3;
      end
      default: r3 = r2_q;
    endcase
  end

  logic [31:0] r3_q;
  logic        l3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      r3_q <= r3;
      l3_q <= l2_q;
    end
  end

  // ---------------- stage 4: output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sample_out_o <= r3_q;
      last_out_o   <= l3_q;
    end
  end
  assign out_valid_o = v4_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !out_ready_i |=> v4_q && $stable(sample_out_o))
    else $error("output changed during stall");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> in_ready_o)
    else $error("pipe stalled with empty output");
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v3_q |=> v4_q)
    else $error("item lost between stage 3 and output");
endmodule
`default_nettype wire
